// ----- design/lfu_pkg.sv -----
// Package for the LFU cache table: sequencer states and operation codes.
// No dependencies; used by lfu_cache_table_unit and its testbench.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIX,
    ST_WRITE,
    ST_DONE
  } lfu_state_e;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

endpackage
`default_nettype wire

// ----- design/lfu_cache_table_unit.sv -----
// LFU cache table top level: entry memory, valid bits and scan sequencer.
// Depends on lfu_pkg.
// Sequence: scan, decide, rank fix, write, done; the result strobe is registered from
// the write state; busy stays high from the accepting edge until the strobe cycle ends.
// A new request is taken only once the last is through: two passes over the entry
// memory (a lookup/victim scan, then a rank-fix pass) read one entry per cycle.
// Reset clears the valid bits, the occupancy and the sequencer at once; capacity
// resets to 16. The receiver cannot stall: each result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_table_unit #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] lookup_key_i,
  input  wire logic [31:0]        write_value_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [4:0]         cfg_capacity_i,
  output logic                    result_valid_o,
  output logic                    hit_o,
  output logic [31:0]             read_value_o,
  output logic                    evicted_o,
  output logic signed [31:0]      evicted_key_o
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int RW = IW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // One memory word holds key, value, count and recency rank.
  localparam int DW = 64 + COUNT_BITS + RW;

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rd_q;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic [DW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [4:0]         cap_q;
  lfu_state_e         state_q, state_d;
  logic [IW:0]        idx_q, idx_d;   // scan address issued
  logic [IW-1:0]      cidx_q, cidx_d; // address of data in rd_q
  logic               rv_q, rv_d;     // rd_q holds scanned data
  logic               op_q;
  logic [31:0]        key_q, val_q;
  logic               found_q, found_d;
  logic [IW-1:0]      fidx_q, fidx_d;
  logic [31:0]        fval_q, fval_d;
  logic [COUNT_BITS-1:0] fcnt_q, fcnt_d;
  logic [RW-1:0]      frank_q, frank_d;
  logic               vic_q, vic_d;
  logic [IW-1:0]      vidx_q, vidx_d;
  logic [COUNT_BITS-1:0] vcnt_q, vcnt_d;
  logic [RW-1:0]      vrank_q, vrank_d;
  logic [31:0]        vkey_q, vkey_d;
  logic               free_q, free_d;
  logic [IW-1:0]      fridx_q, fridx_d;
  // Decision for this request.
  logic               act_q, act_d;   // something changes
  logic               gap_q, gap_d;   // ranks above gapr move down
  logic [RW-1:0]      gapr_q, gapr_d;
  logic [IW-1:0]      tgt_q, tgt_d;
  logic [DW-1:0]      tw_q, tw_d;     // word for the target entry
  logic               hit_q, hit_d, ev_q, ev_d;
  logic [31:0]        rdv_q, rdv_d, evk_q, evk_d;
  logic [OW-1:0]      ecap;

  assign ecap = (32'(cap_q) > ENTRIES) ? OW'(ENTRIES) : OW'(cap_q);
  assign busy = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;

  logic [31:0]           r_key, r_val;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [RW-1:0]         r_rank;
  assign r_key  = rd_q[DW-1 -: 32];
  assign r_val  = rd_q[DW-33 -: 32];
  assign r_cnt  = rd_q[RW +: COUNT_BITS];
  assign r_rank = rd_q[RW-1:0];

  always_comb begin
    logic [OW-1:0] onew;
    state_d = state_q; idx_d = idx_q; cidx_d = cidx_q; rv_d = 1'b0;
    found_d = found_q; fidx_d = fidx_q; fval_d = fval_q; fcnt_d = fcnt_q;
    frank_d = frank_q; vic_d = vic_q; vidx_d = vidx_q; vcnt_d = vcnt_q;
    vrank_d = vrank_q; vkey_d = vkey_q; free_d = free_q; fridx_d = fridx_q;
    act_d = act_q; gap_d = gap_q; gapr_d = gapr_q; tgt_d = tgt_q; tw_d = tw_q;
    hit_d = hit_q; ev_d = ev_q; rdv_d = rdv_q; evk_d = evk_q;
    valid_d = valid_q; occ_d = occ_q;
    raddr = idx_q[IW-1:0]; we = 1'b0; waddr = cidx_q; wdata = rd_q;
    onew = occ_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN; idx_d = '0;
          found_d = 1'b0; vic_d = 1'b0; free_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; examine the word that came back.
        if (idx_q < (IW+1)'(ENTRIES)) begin
          rv_d = 1'b1; cidx_d = idx_q[IW-1:0]; idx_d = idx_q + 1'b1;
        end
        if (rv_q) begin
          if (valid_q[cidx_q]) begin
            if (!found_q && r_key == key_q) begin
              found_d = 1'b1; fidx_d = cidx_q; fval_d = r_val;
              fcnt_d = r_cnt; frank_d = r_rank;
            end
            if (!vic_q || r_cnt < vcnt_q ||
                (r_cnt == vcnt_q && r_rank < vrank_q)) begin
              vic_d = 1'b1; vidx_d = cidx_q; vcnt_d = r_cnt;
              vrank_d = r_rank; vkey_d = r_key;
            end
          end else if (!free_q) begin
            free_d = 1'b1; fridx_d = cidx_q;
          end
        end
        if (rv_q && cidx_q == IW'(ENTRIES-1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        act_d = 1'b0; gap_d = 1'b0; hit_d = 1'b0; ev_d = 1'b0;
        rdv_d = '0; evk_d = '0; gapr_d = frank_q; tgt_d = fidx_q;
        tw_d = {key_q, fval_q, (fcnt_q == CMAX) ? fcnt_q : fcnt_q + 1'b1,
                RW'(occ_q - 1'b1)};
        if (op_q == OP_GET) begin
          if (found_q) begin
            hit_d = 1'b1; rdv_d = fval_q; act_d = 1'b1; gap_d = 1'b1;
          end
        end else if (ecap != '0) begin
          if (found_q) begin
            hit_d = 1'b1; act_d = 1'b1; gap_d = 1'b1;
            tw_d[DW-33 -: 32] = val_q;
          end else begin
            onew = occ_q;
            if (occ_q >= ecap && vic_q) begin
              ev_d = 1'b1; evk_d = vkey_q; gap_d = 1'b1; gapr_d = vrank_q;
              tgt_d = vidx_q; act_d = 1'b1; onew = occ_q - 1'b1;
              valid_d[vidx_q] = 1'b0;
            end else if (free_q) begin
              tgt_d = fridx_q; act_d = 1'b1;
            end
            tw_d = {key_q, val_q, COUNT_BITS'(1), RW'(onew)};
            if (act_d) begin
              occ_d = onew + 1'b1;
            end
          end
        end
        // Exclude the target from the rank fix; it is rewritten afterward.
        if (act_d) valid_d[tgt_d] = 1'b0;
        state_d = ST_FIX; idx_d = '0;
      end
      ST_FIX: begin
        // Second pass: entries ranked above the gap move down by one.
        if (idx_q < (IW+1)'(ENTRIES)) begin
          rv_d = 1'b1; cidx_d = idx_q[IW-1:0]; idx_d = idx_q + 1'b1;
        end
        if (rv_q && gap_q && valid_q[cidx_q] && r_rank > gapr_q) begin
          we = 1'b1; waddr = cidx_q;
          wdata = {rd_q[DW-1:RW], r_rank - 1'b1};
        end
        if (rv_q && cidx_q == IW'(ENTRIES-1)) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (act_q) begin
          we = 1'b1; waddr = tgt_q; wdata = tw_q; valid_d[tgt_q] = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; valid_q <= '0; occ_q <= '0; cap_q <= 5'd16;
      rv_q <= 1'b0; idx_q <= '0; found_q <= 1'b0; vic_q <= 1'b0;
      free_q <= 1'b0; act_q <= 1'b0; gap_q <= 1'b0; result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; valid_q <= valid_d; occ_q <= occ_d; rv_q <= rv_d;
      idx_q <= idx_d; found_q <= found_d; vic_q <= vic_d; free_q <= free_d;
      act_q <= act_d; gap_q <= gap_d;
      result_valid_o <= (state_q == ST_WRITE);
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_capacity_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= operation_i; key_q <= lookup_key_i; val_q <= write_value_i;
    end
    cidx_q <= cidx_d; fidx_q <= fidx_d; fval_q <= fval_d; fcnt_q <= fcnt_d;
    frank_q <= frank_d; vidx_q <= vidx_d; vcnt_q <= vcnt_d; vrank_q <= vrank_d;
    vkey_q <= vkey_d; fridx_q <= fridx_d; gapr_q <= gapr_d; tgt_q <= tgt_d;
    tw_q <= tw_d; hit_q <= hit_d; ev_q <= ev_d; rdv_q <= rdv_d; evk_q <= evk_d;
  end

  assign hit_o         = hit_q;
  assign read_value_o  = rdv_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

`ifndef SYNTHESIS
  a_occ_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(ENTRIES)) else $error("occupancy over depth");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> state_q == ST_DONE) else $error("result strobe misplaced");
  a_ev_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_o) |-> (op_q == OP_PUT && !hit_o))
    else $error("eviction without put miss");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_lfu_cache_table_unit.sv -----
// Self-checking testbench for lfu_cache_table_unit: gets and puts against an
// LFU cache predictor with LRU tie-break, over several capacity settings.
// Depends on lfu_pkg and the lfu_cache_table_unit RTL.
`timescale 1ns / 1ps
module tb_lfu_cache_table_unit;
  import lfu_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  // Settle time, a little longer than one request keeps the block busy.
  localparam int SETTLE     = 2 * ENTRIES + 8;
  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  localparam int NUM_RANDOM = 1030;
  // Ring of expected results; the block has at most one request in flight.
  localparam int PEND_DEPTH = 16;

  typedef struct packed {
    logic              hit;
    logic [31:0]       read_value;
    logic              evicted;
    logic signed [31:0] evicted_key;
  } lookup_result_t;

  // One row of the directed table. A capacity of -1 leaves the register alone;
  // typed rows carry an expected result that is compared instead of the predictor.
  typedef struct {
    int             capacity;
    logic           op;
    logic [31:0]    key;
    logic [31:0]    value;
    bit             typed;
    lookup_result_t result;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = OP_GET;
  logic signed [31:0] lookup_key_i = '0;
  logic [31:0] write_value_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_capacity_i = '0;
  logic result_valid_o;
  logic hit_o;
  logic [31:0] read_value_o;
  logic evicted_o;
  logic signed [31:0] evicted_key_o;

  lfu_cache_table_unit #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_capacity_i(cfg_capacity_i),
    .result_valid_o(result_valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the cache table. Only valid entries are ever read.
  logic                  shadow_valid [ENTRIES];
  logic [31:0]           shadow_key   [ENTRIES];
  logic [31:0]           shadow_value [ENTRIES];
  logic [COUNT_BITS-1:0] shadow_count [ENTRIES];
  int unsigned           shadow_rank  [ENTRIES];
  int unsigned           shadow_occupancy = 0;
  int unsigned           shadow_capacity  = 16;

  lookup_result_t pending_results[PEND_DEPTH];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int idle_cycles = 0;

  // Every valid entry ranked above the given rank moves one step down.
  function automatic void close_rank_gap(int unsigned rank);
    for (int j = 0; j < ENTRIES; j++)
      if (shadow_valid[j] && shadow_rank[j] > rank) shadow_rank[j]--;
  endfunction

  // Bump an entry to most recent and raise its use count, saturating at all ones.
  function automatic void bump_entry(int i);
    shadow_valid[i] = 1'b0;
    close_rank_gap(shadow_rank[i]);
    shadow_valid[i] = 1'b1;
    shadow_rank[i] = shadow_occupancy - 1;
    if (shadow_count[i] != '1) shadow_count[i]++;
  endfunction

  // Works out the result of one request and updates the shadow table with it.
  function automatic lookup_result_t predict_lookup(logic op, logic [31:0] key,
                                                    logic [31:0] value);
    lookup_result_t res;
    int found;
    int slot;
    int victim;
    int unsigned cap;
    res = '0;
    found = -1;
    slot = -1;
    victim = -1;
    cap = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
    for (int j = 0; j < ENTRIES; j++)
      if (found < 0 && shadow_valid[j] && shadow_key[j] == key) found = j;
    if (op == OP_GET) begin
      if (found >= 0) begin
        res.hit = 1'b1;
        res.read_value = shadow_value[found];
        bump_entry(found);
      end
    end else if (cap != 0) begin
      if (found >= 0) begin
        res.hit = 1'b1;
        bump_entry(found);
        shadow_value[found] = value;
      end else begin
        if (shadow_occupancy >= cap) begin
          // Lowest use count loses; on a tie the least recent entry goes.
          for (int j = 0; j < ENTRIES; j++) begin
            if (shadow_valid[j] && (victim < 0 || shadow_count[j] < shadow_count[victim] ||
                (shadow_count[j] == shadow_count[victim] &&
                 shadow_rank[j] < shadow_rank[victim])))
              victim = j;
          end
          if (victim >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = shadow_key[victim];
            shadow_valid[victim] = 1'b0;
            shadow_occupancy--;
            close_rank_gap(shadow_rank[victim]);
            slot = victim;
          end
        end
        for (int j = 0; j < ENTRIES; j++)
          if (slot < 0 && !shadow_valid[j]) slot = j;
        if (slot >= 0) begin
          shadow_valid[slot] = 1'b1;
          shadow_key[slot] = key;
          shadow_value[slot] = value;
          shadow_count[slot] = COUNT_BITS'(1);
          shadow_rank[slot] = shadow_occupancy;
          shadow_occupancy++;
        end
      end
    end
    return res;
  endfunction

  // Presents one request and holds it until the block takes it. Start is left
  // high so that a back-to-back request needs no second assignment.
  task automatic issue_request(logic op, logic [31:0] key, logic [31:0] value,
                               bit typed, lookup_result_t typed_result);
    lookup_result_t predicted;
    start <= 1'b1;
    operation_i <= op;
    lookup_key_i <= key;
    write_value_i <= value;
    do @(posedge clk_i); while (busy);
    predicted = predict_lookup(op, key, value);
    pending_results[requests_sent % PEND_DEPTH] = typed ? typed_result : predicted;
    requests_sent++;
  endtask

  task automatic pause_requests(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // The capacity register is only written once the block has drained.
  task automatic write_capacity(int unsigned cap);
    start <= 1'b0;
    while (results_seen < requests_sent) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_capacity_i <= cap[4:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_capacity = cap;
  endtask

  // Result checker: every strobe must match the oldest pending expectation.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && result_valid_o) begin
      if (hit_o) hits_seen++;
      if (evicted_o) evictions_seen++;
      if (results_seen >= requests_sent) begin
        $error("result strobe with no request outstanding");
        errors++;
      end else begin
        want = pending_results[results_seen % PEND_DEPTH];
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          errors++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, read_value_o);
          errors++;
        end
        if (evicted_o !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted_o);
          errors++;
        end
        if (evicted_key_o !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key_o);
          errors++;
        end
      end
      results_seen++;
    end
  end

  // Watchdog: any transaction on the request, result or register port rearms it.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Directed table. The first rows start from an empty table at capacity 16;
  // lowering the capacity to 1 with two entries resident checks that a put miss
  // evicts exactly one entry and keeps the occupancy.
  directed_row_t directed_rows[] = '{
    '{-1, OP_GET, 32'h0000_0000, 32'h0,          1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF,  1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'h8000_0000, 32'h0,          1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h7FFF_FFFF, 32'h0,          1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h8000_0000, 32'h1234_5678,  1, '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'h8000_0000, 32'hFFFF_FFFF,  1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'hFFFF_FFFF, 32'h0,          1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{ 1, OP_PUT, 32'h0000_0005, 32'h1,          1, '{1'b0, 32'h0, 1'b1, 32'h7FFF_FFFF}},
    '{-1, OP_PUT, 32'h0000_0006, 32'h2,          1, '{1'b0, 32'h0, 1'b1, 32'h5}},
    '{ 0, OP_PUT, 32'h0000_0007, 32'h3,          1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'h8000_0000, 32'h0,          1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'h0000_0007, 32'h0,          1, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{31, OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'hFFFF_FFFF, 32'h0,          0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{ 2, OP_PUT, 32'h0000_0010, 32'hA5A5_A5A5,  0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h0000_0011, 32'h5A5A_5A5A,  0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h0000_0012, 32'h0000_0001,  0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_GET, 32'h0000_0011, 32'h0,          0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{-1, OP_PUT, 32'h0000_0013, 32'hDEAD_BEEF,  0, '{1'b0, 32'h0, 1'b0, 32'h0}},
    '{16, OP_GET, 32'h0000_0013, 32'h0,          0, '{1'b0, 32'h0, 1'b0, 32'h0}}
  };

  logic [31:0] key_pool[24];
  int unsigned capacity_choices[8] = '{0, 1, 2, 3, 8, 16, 17, 31};

  initial begin
    logic op;
    logic [31:0] key;
    logic [31:0] value;
    int gap_left;
    for (int j = 0; j < ENTRIES; j++) begin
      shadow_valid[j] = 1'b0;
      shadow_key[j] = '0;
      shadow_value[j] = '0;
      shadow_count[j] = '0;
      shadow_rank[j] = 0;
    end
    // A small key pool keeps hits, count growth and evictions frequent.
    for (int j = 0; j < 24; j++) key_pool[j] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].capacity >= 0) write_capacity(directed_rows[r].capacity);
      issue_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].value,
                    directed_rows[r].typed, directed_rows[r].result);
    end

    gap_left = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A new capacity setting every 150 requests, extremes included.
      if (n % 150 == 149)
        write_capacity(capacity_choices[$urandom_range(0, 7)]);
      op = 1'($urandom_range(0, 1));
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 23)] : $urandom();
      case ($urandom_range(0, 9))
        0: value = 32'hFFFF_FFFF;
        1: value = 32'h0;
        default: value = $urandom();
      endcase
      // Sender gaps come in bursts; the tail of the run goes back to back.
      if (n < NUM_RANDOM - 100) begin
        if (gap_left == 0 && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
        if (gap_left > 0) begin
          pause_requests(gap_left);
          gap_left = 0;
        end
      end
      issue_request(op, key, value, 1'b0, '0);
    end

    start <= 1'b0;
    while (results_seen < requests_sent) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Ran %0d requests over capacities 0 to 31 with %0d results checked.",
             requests_sent, results_seen);
    $display("Saw %0d hits and %0d evictions.", hits_seen, evictions_seen);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
